FILE: hw/rtl/lfu_pkg.sv
// Shared types, constants and control structs for the LFU cache table.
package lfu_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam longint unsigned COUNT_MAX_DEF = 64'd65535;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] value_t;
  typedef logic [CAP_W-1:0] capacity_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;        // latch the request
    logic look;          // key match, free slot search, value read
    logic touch;         // hit: bump count, move to most recent
    logic insert_free;   // miss with room: fill first free slot
    logic scan_start;    // clear victim search
    logic scan_step;     // examine one entry for the victim
    logic evict_insert;  // replace victim with the new key
    logic rsp_zero;      // all-zero result
    logic rsp_load;      // move result into the output register
  } lfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic is_put;
    logic cap_zero;
    logic full;
    logic scan_last;
    logic out_busy;
  } lfu_stat_t;

endpackage

FILE: hw/rtl/lfu_if.sv
// Handshake channel interfaces: request, response and capacity write.
interface lfu_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  lfu_pkg::key_t     lookup_key;
  lfu_pkg::value_t   write_value;

  modport source (output valid, operation, lookup_key, write_value, input ready);
  modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

interface lfu_out_if;
  logic              valid;
  logic              ready;
  logic              hit;
  lfu_pkg::value_t   read_value;
  logic              evicted;
  lfu_pkg::key_t     evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  logic                 valid;
  logic                 ready;
  lfu_pkg::capacity_t   capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

FILE: hw/rtl/lfu_ctrl.sv
// Sequencing state machine for the LFU cache table.
module lfu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfu_pkg::lfu_stat_t stat,
  output lfu_pkg::lfu_cmd_t  cmd
);
  import lfu_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_ACT   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_EVICT = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_ACT;
      end
      S_ACT: begin
        if (stat.is_put && stat.cap_zero) begin
          cmd.rsp_zero = 1'b1;
          state_nxt    = S_RESP;
        end else if (stat.hit) begin
          cmd.touch = 1'b1;
          state_nxt = S_RESP;
        end else if (!stat.is_put) begin
          cmd.rsp_zero = 1'b1;
          state_nxt    = S_RESP;
        end else if (stat.full) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.insert_free = 1'b1;
          state_nxt       = S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.evict_insert = 1'b1;
        state_nxt        = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.rsp_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_look_to_act: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |=> (state_r == S_ACT))
    else $error("lookup not followed by decision");

  a_scan_ends_in_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.scan_last) |=> (state_r == S_EVICT))
    else $error("victim scan did not end in eviction");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (state_r == S_IDLE))
    else $error("request accepted outside idle");

endmodule

FILE: hw/rtl/lfu_dp.sv
// Entry storage, key match, victim search and result registers.
module lfu_dp #(
  parameter int unsigned      ENTRIES   = lfu_pkg::ENTRIES_DEF,
  parameter longint unsigned  COUNT_MAX = lfu_pkg::COUNT_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfu_pkg::lfu_cmd_t    cmd,
  output lfu_pkg::lfu_stat_t   stat,
  input  logic                 in_operation,
  input  lfu_pkg::key_t        in_key,
  input  lfu_pkg::value_t      in_value,
  input  logic                 cfg_valid,
  input  lfu_pkg::capacity_t   cfg_capacity,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_hit,
  output lfu_pkg::value_t      out_read_value,
  output logic                 out_evicted,
  output lfu_pkg::key_t        out_evicted_key
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CNT_W = $clog2(COUNT_MAX + 64'd1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [CNT_W-1:0] CNT_MAX_V = CNT_W'(COUNT_MAX);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ENTRIES - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(ENTRIES);

  // request
  logic       op_r;
  key_t       key_r;
  value_t     wval_r;
  capacity_t  capacity_r;

  // entries
  logic [ENTRIES-1:0] valid_r;
  key_t               key_q [ENTRIES];
  logic [CNT_W-1:0]   cnt_q [ENTRIES];
  logic [IDX_W-1:0]   rec_q [ENTRIES];
  value_t             mem   [ENTRIES];
  value_t             rdata_r;
  logic [OCC_W-1:0]   occ_r;

  // lookup results
  logic              hit_r;
  logic [IDX_W-1:0]  hidx_r, fidx_r;

  // victim search
  logic [IDX_W-1:0]  scan_idx_r, best_idx_r, best_rec_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic              best_found_r;

  // result staging and output register
  logic    res_hit_r, res_evicted_r;
  value_t  res_rd_r;
  key_t    res_evk_r;
  logic    out_valid_r, out_hit_r, out_evicted_r;
  value_t  out_rd_r;
  key_t    out_evk_r;

  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   match_idx, free_idx;
  logic               any_match;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_q[i] == key_r);
      if (match[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    any_match = |match;
  end

  logic              rl_en;
  logic [IDX_W-1:0]  rl_slot, rl_old, rl_new, ins_slot;
  logic [CNT_W-1:0]  cnt_old, cnt_inc;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              scan_better;

  always_comb begin
    rl_en    = cmd.touch || cmd.evict_insert;
    rl_slot  = cmd.touch ? hidx_r : best_idx_r;
    rl_old   = rec_q[rl_slot];
    rl_new   = IDX_W'(occ_r - OCC_W'(1));
    ins_slot = cmd.evict_insert ? best_idx_r : fidx_r;
    cnt_old  = cnt_q[hidx_r];
    cnt_inc  = (cnt_old == CNT_MAX_V) ? cnt_old : cnt_old + CNT_ONE;
    wr_en    = (cmd.touch && (op_r == OP_PUT)) || cmd.insert_free || cmd.evict_insert;
    wr_addr  = cmd.touch ? hidx_r : ins_slot;
    scan_better = valid_r[scan_idx_r] &&
                  (!best_found_r || (cnt_q[scan_idx_r] < best_cnt_r) ||
                   ((cnt_q[scan_idx_r] == best_cnt_r) && (rec_q[scan_idx_r] < best_rec_r)));
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity_r <= cfg_capacity;
      end
      if (cmd.insert_free) begin
        valid_r[fidx_r] <= 1'b1;
        occ_r           <= occ_r + OCC_W'(1);
      end
      if (cmd.rsp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and lookup
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      key_r  <= in_key;
      wval_r <= in_value;
    end
    if (cmd.look) begin
      hit_r   <= any_match;
      hidx_r  <= match_idx;
      fidx_r  <= free_idx;
      rdata_r <= mem[match_idx];
    end
    if (wr_en) begin
      mem[wr_addr] <= wval_r;
    end
  end

  // per-entry key, count and recency rank
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (rl_en && valid_r[i] && (IDX_W'(i) != rl_slot) && (rec_q[i] > rl_old)) begin
        rec_q[i] <= rec_q[i] - IDX_W'(1);
      end
      if (rl_en && (IDX_W'(i) == rl_slot)) begin
        rec_q[i] <= rl_new;
      end
      if (cmd.insert_free && (IDX_W'(i) == fidx_r)) begin
        rec_q[i] <= IDX_W'(occ_r);
      end
      if (cmd.touch && (IDX_W'(i) == hidx_r)) begin
        cnt_q[i] <= cnt_inc;
      end
      if ((cmd.insert_free || cmd.evict_insert) && (IDX_W'(i) == ins_slot)) begin
        cnt_q[i] <= CNT_ONE;
        key_q[i] <= key_r;
      end
    end
  end

  // victim search: lowest count, then least recent
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      if (scan_better) begin
        best_found_r <= 1'b1;
        best_idx_r   <= scan_idx_r;
        best_cnt_r   <= cnt_q[scan_idx_r];
        best_rec_r   <= rec_q[scan_idx_r];
      end
    end
  end

  // result staging and output payload
  always_ff @(posedge clk) begin
    if (cmd.rsp_zero || cmd.insert_free) begin
      res_hit_r     <= 1'b0;
      res_rd_r      <= '0;
      res_evicted_r <= 1'b0;
      res_evk_r     <= '0;
    end else if (cmd.touch) begin
      res_hit_r     <= 1'b1;
      res_rd_r      <= (op_r == OP_PUT) ? '0 : rdata_r;
      res_evicted_r <= 1'b0;
      res_evk_r     <= '0;
    end else if (cmd.evict_insert) begin
      res_hit_r     <= 1'b0;
      res_rd_r      <= '0;
      res_evicted_r <= 1'b1;
      res_evk_r     <= key_q[best_idx_r];
    end
    if (cmd.rsp_load) begin
      out_hit_r     <= res_hit_r;
      out_rd_r      <= res_rd_r;
      out_evicted_r <= res_evicted_r;
      out_evk_r     <= res_evk_r;
    end
  end

  always_comb begin
    stat.hit       = hit_r;
    stat.is_put    = (op_r == OP_PUT);
    stat.cap_zero  = (capacity_r == '0);
    stat.full      = (CMP_W'(occ_r) >= CMP_W'(capacity_r)) || (occ_r == OCC_FULL);
    stat.scan_last = (scan_idx_r == IDX_LAST);
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evk_r;

  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    OCC_W'($countones(valid_r)) == occ_r)
    else $error("occupancy out of step with valid bits");

  a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict_insert |-> best_found_r && valid_r[best_idx_r])
    else $error("eviction without a valid victim");

  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert_free |-> !valid_r[fidx_r] && (occ_r != OCC_FULL))
    else $error("insert into an occupied slot");

  a_touch_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.touch |-> hit_r && valid_r[hidx_r])
    else $error("touch of an entry that did not match");

endmodule

FILE: hw/rtl/lfu_cache_table_core.sv
// Top level of the LFU cache table: controller, datapath and channel hookup.
//
// Usage:
//   in_ch   request channel (valid/ready): operation (0 get, 1 put), lookup_key,
//           write_value. One request is in flight at a time.
//   out_ch  response channel (valid/ready): hit, read_value, evicted,
//           evicted_key. Exactly one response per request, in order.
//   cfg_ch  capacity write channel; always ready. Write only while idle.
// Steps per request, accept to response valid: get, put hit, put with free
//   room or zero capacity: lookup, decision, output load. Put miss on a
//   full table: lookup, decision, victim search, eviction, output load;
//   the victim search walks the count/recency registers one entry per cycle.
//   in_ch.ready returns the cycle after the response is loaded.
// Reset (rst_n, synchronous): table empty, capacity 16, no response pending.
// A stalled out_ch holds its response; the next finished response waits in
// the datapath until the output register frees, and no request is taken
// meanwhile.
module lfu_cache_table_core #(
  parameter int unsigned     ENTRIES   = lfu_pkg::ENTRIES_DEF,
  parameter longint unsigned COUNT_MAX = lfu_pkg::COUNT_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lfu_in_if.sink    in_ch,
  lfu_out_if.source out_ch,
  lfu_cfg_if.sink   cfg_ch
);
  import lfu_pkg::*;

  lfu_cmd_t  cmd;
  lfu_stat_t stat;
  logic      cfg_we;

  // capacity writes never stall
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfu_dp #(
    .ENTRIES   (ENTRIES),
    .COUNT_MAX (COUNT_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_ch.operation),
    .in_key          (in_ch.lookup_key),
    .in_value        (in_ch.write_value),
    .cfg_valid       (cfg_we),
    .cfg_capacity    (cfg_ch.capacity),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_hit         (out_ch.hit),
    .out_read_value  (out_ch.read_value),
    .out_evicted     (out_ch.evicted),
    .out_evicted_key (out_ch.evicted_key)
  );

endmodule
